// ----- design/ipv4_dotted_quad_checker_macros.svh -----
// Assertion macros for the checker RTL.
`ifndef IPV4_DOTTED_QUAD_CHECKER_MACROS_SVH
`define IPV4_DOTTED_QUAD_CHECKER_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons)
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons)
`endif

`endif

// ----- design/ipdq_pkg.sv -----
`timescale 1ns / 1ps

package ipdq_pkg;

  localparam logic [7:0] CHAR_DOT  = 8'h2E;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic [4:0] LEN_MIN     = 5'd7;
  localparam logic [4:0] LEN_MAX     = 5'd15;
  localparam logic [4:0] LEN_SAT     = 5'd31;
  localparam logic [2:0] DOTS_NEEDED = 3'd3;
  localparam logic [2:0] COUNT_SAT   = 3'd7;
  localparam logic [2:0] DIGITS_MAX  = 3'd3;
  localparam logic [8:0] PART_MAX    = 9'd255;
  localparam logic [8:0] PART_SAT    = 9'd256;

  typedef enum logic [3:0] {
    ST_VALID          = 4'd0,
    ST_BAD_LENGTH     = 4'd1,
    ST_BAD_CHAR       = 4'd2,
    ST_BAD_DOTS       = 4'd3,
    ST_LEADING_DOT    = 4'd4,
    ST_EMPTY_PART     = 4'd5,
    ST_ALL_ZERO       = 4'd6,
    ST_LEADING_ZERO   = 4'd7,
    ST_OVER_255       = 4'd8,
    ST_ZERO_AFTER_DOT = 4'd9,
    ST_LONG_PART      = 4'd10
  } status_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } item_t;

  // The pattern "0.0.0.0": digits at even positions, dots at odd ones.
  function automatic logic [7:0] zero_quad_char(input logic [2:0] idx);
    return idx[0] ? CHAR_DOT : CHAR_ZERO;
  endfunction

endpackage

// ----- design/ipdq_in_stage.sv -----
`timescale 1ns / 1ps

module ipdq_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  ipdq_pkg::item_t in_item,
  input  logic           advance,
  output logic           in_stall,
  output logic           held_valid,
  output ipdq_pkg::item_t held_item
);
  import ipdq_pkg::*;

  logic accept;

  // A new transfer is taken when the stage is empty or the held byte leaves in the same cycle.
  assign in_stall = held_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_item <= in_item;
    end
  end

endmodule

// ----- design/ipdq_scan.sv -----
`timescale 1ns / 1ps

module ipdq_scan (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  ipdq_pkg::item_t   item,
  output ipdq_pkg::status_t status_next
);
  import ipdq_pkg::*;

  logic [4:0] length_count, length_count_next;
  logic [2:0] dot_count, dot_count_next;
  logic [7:0] first_byte, first_byte_next;
  logic       prev_was_dot, prev_was_dot_next;
  logic       bad_char_seen, bad_char_seen_next;
  logic       double_dot_seen, double_dot_seen_next;
  logic       zero_after_dot_seen, zero_after_dot_seen_next;
  logic [8:0] part_value, part_value_next;
  logic       over_limit_seen, over_limit_seen_next;
  logic [2:0] part_digit_count, part_digit_count_next;
  logic       long_part_seen, long_part_seen_next;
  logic       all_zero_match, all_zero_match_next;

  logic        is_dot;
  logic        is_digit;
  logic [11:0] part_sum;

  assign is_dot   = (item.char_code == CHAR_DOT);
  assign is_digit = (item.char_code >= CHAR_ZERO) && (item.char_code <= CHAR_NINE);
  // Value times ten plus the digit; the low nibble of an ASCII digit is its value.
  assign part_sum = ({3'b000, part_value} * 12'd10) + {8'h00, item.char_code[3:0]};

  always_comb begin
    length_count_next        = (length_count < LEN_SAT) ? length_count + 5'd1 : length_count;
    first_byte_next          = (length_count == 5'd0) ? item.char_code : first_byte;
    all_zero_match_next      = (length_count < LEN_MIN) ?
        (all_zero_match && (item.char_code == zero_quad_char(length_count[2:0]))) : 1'b0;
    dot_count_next           = dot_count;
    prev_was_dot_next        = 1'b0;
    bad_char_seen_next       = bad_char_seen;
    double_dot_seen_next     = double_dot_seen;
    zero_after_dot_seen_next = zero_after_dot_seen;
    part_value_next          = part_value;
    over_limit_seen_next     = over_limit_seen;
    part_digit_count_next    = part_digit_count;
    long_part_seen_next      = long_part_seen;

    if (is_dot) begin
      double_dot_seen_next  = double_dot_seen || prev_was_dot;
      dot_count_next        = (dot_count < COUNT_SAT) ? dot_count + 3'd1 : dot_count;
      part_value_next       = 9'd0;
      part_digit_count_next = 3'd0;
      prev_was_dot_next     = 1'b1;
    end else if (is_digit) begin
      zero_after_dot_seen_next = zero_after_dot_seen ||
                                 (prev_was_dot && (item.char_code == CHAR_ZERO));
      if (part_sum > {3'b000, PART_MAX}) begin
        part_value_next      = PART_SAT;
        over_limit_seen_next = 1'b1;
      end else begin
        part_value_next = part_sum[8:0];
      end
      part_digit_count_next = (part_digit_count < COUNT_SAT) ?
                              part_digit_count + 3'd1 : part_digit_count;
      // The digit count is judged after this digit is added.
      long_part_seen_next   = long_part_seen || (part_digit_count_next > DIGITS_MAX);
    end else begin
      bad_char_seen_next = 1'b1;
    end
  end

  // Status is taken from the state as it stands after this byte.
  always_comb begin
    if ((length_count_next < LEN_MIN) || (length_count_next > LEN_MAX)) begin
      status_next = ST_BAD_LENGTH;
    end else if (bad_char_seen_next) begin
      status_next = ST_BAD_CHAR;
    end else if (dot_count_next != DOTS_NEEDED) begin
      status_next = ST_BAD_DOTS;
    end else if (first_byte_next == CHAR_DOT) begin
      status_next = ST_LEADING_DOT;
    end else if (double_dot_seen_next || prev_was_dot_next) begin
      status_next = ST_EMPTY_PART;
    end else if ((length_count_next == LEN_MIN) && all_zero_match_next) begin
      status_next = ST_ALL_ZERO;
    end else if (first_byte_next == CHAR_ZERO) begin
      status_next = ST_LEADING_ZERO;
    end else if (over_limit_seen_next) begin
      status_next = ST_OVER_255;
    end else if (zero_after_dot_seen_next) begin
      status_next = ST_ZERO_AFTER_DOT;
    end else if (long_part_seen_next) begin
      status_next = ST_LONG_PART;
    end else begin
      status_next = ST_VALID;
    end
  end

  // The last byte of a string returns everything to the reset state.
  always_ff @(posedge clk) begin
    if (rst || (advance && item.last)) begin
      length_count        <= 5'd0;
      dot_count           <= 3'd0;
      first_byte          <= 8'h00;
      prev_was_dot        <= 1'b0;
      bad_char_seen       <= 1'b0;
      double_dot_seen     <= 1'b0;
      zero_after_dot_seen <= 1'b0;
      part_value          <= 9'd0;
      over_limit_seen     <= 1'b0;
      part_digit_count    <= 3'd0;
      long_part_seen      <= 1'b0;
      all_zero_match      <= 1'b1;
    end else if (advance) begin
      length_count        <= length_count_next;
      dot_count           <= dot_count_next;
      first_byte          <= first_byte_next;
      prev_was_dot        <= prev_was_dot_next;
      bad_char_seen       <= bad_char_seen_next;
      double_dot_seen     <= double_dot_seen_next;
      zero_after_dot_seen <= zero_after_dot_seen_next;
      part_value          <= part_value_next;
      over_limit_seen     <= over_limit_seen_next;
      part_digit_count    <= part_digit_count_next;
      long_part_seen      <= long_part_seen_next;
      all_zero_match      <= all_zero_match_next;
    end
  end

endmodule

// ----- design/ipdq_out_stage.sv -----
`timescale 1ns / 1ps

module ipdq_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  ipdq_pkg::status_t status_next,
  input  logic              out_stall,
  output logic              out_ready,
  output logic              out_valid,
  output ipdq_pkg::status_t status_held
);
  import ipdq_pkg::*;

  // The register can take a new status when empty or when its transfer completes now.
  assign out_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_held <= status_next;
    end
  end

endmodule

// ----- design/ipv4_dotted_quad_checker.sv -----
// The last byte of a string waits in the input register until the status register has
// room; the status register then loads, and the status is offered from it.
// Throughput: one byte per cycle unless a last byte waits for status room; each
// byte updates the running flags in one pass between input and status registers.
// Reset (rst, synchronous, active high) empties both registers and clears the scan
// state; the last byte of each string also returns the scan state to reset.
`timescale 1ns / 1ps
`include "ipv4_dotted_quad_checker_macros.svh"

module ipv4_dotted_quad_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] char_code,
  input  logic       last,
  input  logic       in_valid,
  output logic       in_stall,
  output logic [3:0] status,
  output logic       out_valid,
  input  logic       out_stall
);
  import ipdq_pkg::*;

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    advance;
  logic    out_ready;
  status_t status_next;
  status_t status_held;

  assign in_item.char_code = char_code;
  assign in_item.last      = last;

  // Only the last byte needs room in the status register.
  assign advance = held_valid && (!held_item.last || out_ready);
  assign status  = status_held;

  ipdq_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .advance    (advance),
    .in_stall   (in_stall),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  ipdq_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .item        (held_item),
    .status_next (status_next)
  );

  ipdq_out_stage u_out_stage (
    .clk         (clk),
    .rst         (rst),
    .load        (advance && held_item.last),
    .status_next (status_next),
    .out_stall   (out_stall),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .status_held (status_held)
  );

  `ASSERT_SAME_CYCLE(a_stall_needs_byte, clk, rst, in_stall, held_valid)
  `ASSERT_SAME_CYCLE(a_status_in_range, clk, rst, out_valid, status_held <= ST_LONG_PART)
  `ASSERT_NEXT_CYCLE(a_last_gives_result, clk, rst, advance && held_item.last, out_valid)
  `ASSERT_NEXT_CYCLE(a_inner_byte_silent, clk, rst,
                     advance && !held_item.last && out_valid && !out_stall, !out_valid)

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import ipdq_pkg::*;

  localparam int RANDOM_BYTES = 520;
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 150;
  localparam int TAIL_CYCLES  = 10;

  typedef struct packed {
    logic [4:0] len;
    logic [2:0] dots;
    logic [7:0] first;
    logic       prev_dot;
    logic       bad_char;
    logic       dbl_dot;
    logic       zero_after_dot;
    logic [8:0] part;
    logic       over;
    logic [2:0] digits;
    logic       long_part;
    logic       zero_quad_ok;
  } scan_t;

  typedef struct packed {
    logic [7:0] code;
    logic       fin;
  } xfer_t;

  typedef struct packed {
    logic    known;
    status_t code;
  } fixed_t;

  typedef struct {
    string      text;
    int         poke_at;
    logic [7:0] poke_val;
    bit         known;
    status_t    code;
  } row_t;

  // Rows without a typed status are checked against the scan predictor.
  row_t dir_rows [25] = '{
    '{"1.2.3.4",            -1, 8'h00, 1'b1, ST_VALID},
    '{"255.255.255.255",    -1, 8'h00, 1'b1, ST_VALID},
    '{"7",                  -1, 8'h00, 1'b1, ST_BAD_LENGTH},
    '{"1.2.3",              -1, 8'h00, 1'b1, ST_BAD_LENGTH},
    '{"100.200.100.2001",   -1, 8'h00, 1'b1, ST_BAD_LENGTH},
    '{"1234567890123456789012345678901234567", -1, 8'h00, 1'b1, ST_BAD_LENGTH},
    '{"1.2.3.4",             6, 8'h00, 1'b1, ST_BAD_CHAR},
    '{"1.2.3.4",             0, 8'hFF, 1'b1, ST_BAD_CHAR},
    '{"10.2.3.4",            1, 8'h2F, 1'b1, ST_BAD_CHAR},
    '{"10.2.3.4",            1, 8'h3A, 1'b1, ST_BAD_CHAR},
    '{"1.2.3.4.5",          -1, 8'h00, 1'b1, ST_BAD_DOTS},
    '{"12.34.56",           -1, 8'h00, 1'b1, ST_BAD_DOTS},
    '{".1.2.34",            -1, 8'h00, 1'b1, ST_LEADING_DOT},
    '{"1..2.34",            -1, 8'h00, 1'b1, ST_EMPTY_PART},
    '{"1.2.34.",            -1, 8'h00, 1'b1, ST_EMPTY_PART},
    '{"0.0.0.0",            -1, 8'h00, 1'b1, ST_ALL_ZERO},
    '{"0.0.0.00",           -1, 8'h00, 1'b1, ST_LEADING_ZERO},
    '{"01.2.3.4",           -1, 8'h00, 1'b1, ST_LEADING_ZERO},
    '{"1.2.3.256",          -1, 8'h00, 1'b1, ST_OVER_255},
    '{"1.999.3.4",          -1, 8'h00, 1'b1, ST_OVER_255},
    '{"1.2.03.4",           -1, 8'h00, 1'b1, ST_ZERO_AFTER_DOT},
    '{"9.0.0.0",            -1, 8'h00, 1'b1, ST_ZERO_AFTER_DOT},
    '{"1.2.3.0001",         -1, 8'h00, 1'b0, ST_VALID},
    '{"10.20.30.40",        -1, 8'h00, 1'b0, ST_VALID},
    '{"9.87.6.54",          -1, 8'h00, 1'b0, ST_VALID}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic [7:0] char_code = 8'h00;
  logic       last = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [3:0] status;
  logic       out_valid;
  logic       out_stall = 1'b0;

  xfer_t   tx_q[$];
  fixed_t  fixed_q[$];
  status_t status_due_q[$];
  scan_t   scan;

  logic in_took = 1'b0;
  logic pressure_on = 1'b0;
  bit   pressure_done = 1'b0;
  int   burst_left = 0;
  int   gap_left = 0;
  int   hold_left = 0;
  int   rx_mode = 0;
  int   rx_span = 0;
  int   rx_phase = 0;
  int   idle_cycles = 0;
  int   queued_bytes = 0;
  int   queued_strings = 0;
  int   accepted_bytes = 0;
  int   statuses_checked = 0;
  int   mismatches = 0;
  int   code_hits [16];

  ipv4_dotted_quad_checker u_dut (
    .clk       (clk),
    .rst       (rst),
    .char_code (char_code),
    .last      (last),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic clear_scan();
    scan = '0;
    scan.zero_quad_ok = 1'b1;
  endtask

  function automatic status_t quad_verdict(input scan_t s);
    if (s.len < LEN_MIN || s.len > LEN_MAX) return ST_BAD_LENGTH;
    if (s.bad_char) return ST_BAD_CHAR;
    if (s.dots != DOTS_NEEDED) return ST_BAD_DOTS;
    if (s.first == CHAR_DOT) return ST_LEADING_DOT;
    if (s.dbl_dot || s.prev_dot) return ST_EMPTY_PART;
    if (s.len == LEN_MIN && s.zero_quad_ok) return ST_ALL_ZERO;
    if (s.first == CHAR_ZERO) return ST_LEADING_ZERO;
    if (s.over) return ST_OVER_255;
    if (s.zero_after_dot) return ST_ZERO_AFTER_DOT;
    if (s.long_part) return ST_LONG_PART;
    return ST_VALID;
  endfunction

  // Advances the scan by one byte; on the final byte it yields the status and clears.
  task automatic scan_byte(input logic [7:0] c, input logic fin, output bit done,
                           output status_t code);
    int v;
    bit is_dot;
    bit is_digit;
    is_dot = (c == CHAR_DOT);
    is_digit = (c >= CHAR_ZERO && c <= CHAR_NINE);
    done = fin;
    code = ST_VALID;
    if (scan.len == 0) scan.first = c;
    // "0.0.0.0" has zeros at even positions and dots at odd ones.
    if (scan.len < LEN_MIN) begin
      if (c != (scan.len[0] ? CHAR_DOT : CHAR_ZERO)) scan.zero_quad_ok = 1'b0;
    end else begin
      scan.zero_quad_ok = 1'b0;
    end
    if (scan.len != LEN_SAT) scan.len = scan.len + 5'd1;
    if (is_dot) begin
      if (scan.prev_dot) scan.dbl_dot = 1'b1;
      if (scan.dots != COUNT_SAT) scan.dots = scan.dots + 3'd1;
      scan.part = '0;
      scan.digits = '0;
      scan.prev_dot = 1'b1;
    end else if (is_digit) begin
      if (scan.prev_dot && c == CHAR_ZERO) scan.zero_after_dot = 1'b1;
      v = int'(scan.part) * 10 + int'(c - CHAR_ZERO);
      if (v > int'(PART_MAX)) begin
        v = int'(PART_SAT);
        scan.over = 1'b1;
      end
      scan.part = v[8:0];
      if (scan.digits != COUNT_SAT) scan.digits = scan.digits + 3'd1;
      if (scan.digits > DIGITS_MAX) scan.long_part = 1'b1;
      scan.prev_dot = 1'b0;
    end else begin
      scan.bad_char = 1'b1;
      scan.prev_dot = 1'b0;
    end
    if (fin) begin
      code = quad_verdict(scan);
      clear_scan();
    end
  endtask

  task automatic append_text(ref logic [7:0] q[$], input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endtask

  task automatic queue_string(input logic [7:0] txt[$], input bit known, input status_t code);
    fixed_t fx;
    foreach (txt[i]) tx_q.push_back('{txt[i], (i == txt.size() - 1)});
    fx.known = known;
    fx.code = code;
    fixed_q.push_back(fx);
    queued_bytes += txt.size();
    queued_strings++;
  endtask

  // Mostly four-part addresses with random values, some of them damaged, plus noise.
  task automatic add_random_string();
    logic [7:0] txt[$];
    int kind;
    int v;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 75) begin
      for (int p = 0; p < 4; p++) begin
        if (p != 0) txt.push_back(CHAR_DOT);
        v = ($urandom_range(0, 9) == 0) ? $urandom_range(256, 999) : $urandom_range(0, 255);
        if ($urandom_range(0, 3) == 0) v = $urandom_range(0, 9);
        if ($urandom_range(0, 19) == 0) txt.push_back(CHAR_ZERO);
        append_text(txt, $sformatf("%0d", v));
      end
      if ($urandom_range(0, 49) == 0) begin
        txt.delete();
        append_text(txt, "0.0.0.0");
      end
      if (kind >= 55) begin
        case ($urandom_range(0, 5))
          0: txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
          1: txt.insert($urandom_range(0, txt.size()), CHAR_DOT);
          2: txt.delete($urandom_range(0, txt.size() - 1));
          3: txt.push_back(CHAR_DOT);
          4: txt.push_front(CHAR_DOT);
          default: txt.push_front(CHAR_ZERO);
        endcase
      end
    end else if (kind < 90) begin
      n = $urandom_range(1, 40);
      repeat (n) begin
        if ($urandom_range(0, 3) == 0) txt.push_back(CHAR_DOT);
        else txt.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
      end
    end else begin
      n = $urandom_range(1, 35);
      repeat (n) txt.push_back(8'($urandom_range(0, 255)));
    end
    queue_string(txt, 1'b0, ST_VALID);
  endtask

  always @(negedge clk) begin : sender
    logic offer;
    offer = 1'b0;
    if (in_took) void'(tx_q.pop_front());
    if (rst) begin
      offer = 1'b0;
    end else if (in_valid && !in_took) begin
      offer = 1'b1;
    end else if (gap_left > 0 && !pressure_on) begin
      gap_left--;
    end else if (tx_q.size() != 0) begin
      offer = 1'b1;
      gap_left = 0;
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 30);
        gap_left = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left--;
      end
    end
    in_valid <= offer;
    if (offer) begin
      char_code <= tx_q[0].code;
      last <= tx_q[0].fin;
    end
  end

  // The receiver changes its stall pattern now and then, and once holds off long
  // enough that the block has to stall its input.
  always @(negedge clk) begin : receiver
    logic stall_now;
    logic hold_now;
    stall_now = 1'b0;
    hold_now = 1'b0;
    rx_phase++;
    if (hold_left > 0) begin
      hold_left--;
      stall_now = 1'b1;
      hold_now = 1'b1;
    end else if (!pressure_done && accepted_bytes >= 300) begin
      pressure_done = 1'b1;
      hold_left = HOLD_CYCLES;
      stall_now = 1'b1;
      hold_now = 1'b1;
    end else begin
      if (rx_span == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_span = $urandom_range(10, 60);
      end else begin
        rx_span--;
      end
      case (rx_mode)
        0: stall_now = 1'b0;
        1: stall_now = 1'($urandom_range(0, 1));
        2: stall_now = (rx_phase % 3 != 0);
        default: stall_now = ($urandom_range(0, 7) == 0);
      endcase
    end
    out_stall <= stall_now;
    pressure_on <= hold_now;
  end

  always @(posedge clk) begin : monitor
    bit done;
    status_t code;
    fixed_t fx;
    in_took <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      accepted_bytes++;
      scan_byte(char_code, last, done, code);
      if (done) begin
        fx = fixed_q.pop_front();
        status_due_q.push_back(fx.known ? fx.code : code);
      end
    end
    if (!rst && out_valid && !out_stall) begin
      if (status_due_q.size() == 0) begin
        $display("%0t: status transfer %0d with no status expected", $realtime, status);
        mismatches++;
      end else begin
        code = status_due_q.pop_front();
        statuses_checked++;
        code_hits[status]++;
        if (status !== code) begin
          $display("%0t: status mismatch, expected %0d (%s), actual %0d", $realtime,
                   code, code.name(), status);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d statuses outstanding", $realtime,
                 IDLE_LIMIT, status_due_q.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin : main
    logic [7:0] txt[$];
    int dir_bytes;
    int codes_seen;
    clear_scan();
    foreach (dir_rows[r]) begin
      txt.delete();
      append_text(txt, dir_rows[r].text);
      if (dir_rows[r].poke_at >= 0) txt[dir_rows[r].poke_at] = dir_rows[r].poke_val;
      queue_string(txt, dir_rows[r].known, dir_rows[r].code);
    end
    dir_bytes = queued_bytes;
    while (queued_bytes < dir_bytes + RANDOM_BYTES) add_random_string();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (tx_q.size() != 0 || in_valid) @(negedge clk);
    while (status_due_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    codes_seen = 0;
    foreach (code_hits[i]) if (code_hits[i] != 0) codes_seen++;
    $display("Sent %0d strings (%0d bytes), checked %0d statuses covering %0d codes.",
             queued_strings, accepted_bytes, statuses_checked, codes_seen);
    $display("Long receiver hold-off applied: %0d, mismatches: %0d", pressure_done, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
